// ===== design/fbt_pkg.sv =====
// fbt_pkg: shared types, constants, cordic angle table and microprogram
// for the frenet back transformation unit
// no dependencies
package fbt_pkg;

	localparam int QW                = 64;
	localparam int VALUE_WIDTH_DEF   = 48;
	localparam int NUM_OPS           = 15;
	localparam int MEM_DEPTH         = 64;

	typedef logic [5:0] raddr_t;
	typedef logic [7:0] pc_t;
	typedef logic [3:0] uop_t;

	typedef struct packed {
		uop_t   op;
		raddr_t dst;
		raddr_t a;
		raddr_t b;
		pc_t    imm;
	} uinstr_t;

	// micro-ops
	localparam uop_t OP_ADD  = 4'd0;
	localparam uop_t OP_SUB  = 4'd1;
	localparam uop_t OP_MUL  = 4'd2;
	localparam uop_t OP_DIV  = 4'd3;
	localparam uop_t OP_GRD  = 4'd4;
	localparam uop_t OP_ATAN = 4'd5;
	localparam uop_t OP_SC   = 4'd6;
	localparam uop_t OP_LDC  = 4'd7;
	localparam uop_t OP_EMIT = 4'd8;
	localparam uop_t OP_JDIS = 4'd9;
	localparam uop_t OP_JARC = 4'd10;
	localparam uop_t OP_JMP  = 4'd11;

	// constant selects for OP_LDC
	localparam pc_t C_ZERO = 8'd0;
	localparam pc_t C_ONE  = 8'd1;

	localparam pc_t RESULT_LAST = 8'd9;

	localparam logic signed [QW-1:0] Q_ONE  = 64'sh1_0000_0000;
	localparam logic signed [QW-1:0] Q_EPS  = 64'sd4295;
	localparam logic signed [QW-1:0] Q_HPI  = 64'sh1_921F_B544;
	localparam logic signed [QW-1:0] Q_GAIN = 64'sh9B74_EDA8;
	localparam logic signed [QW-1:0] Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;

	// operand slots
	localparam raddr_t O_V    = 6'd0;
	localparam raddr_t O_A    = 6'd1;
	localparam raddr_t O_D    = 6'd2;
	localparam raddr_t O_KR   = 6'd3;
	localparam raddr_t O_KRP  = 6'd4;
	localparam raddr_t O_DP1  = 6'd5;
	localparam raddr_t O_DP2  = 6'd6;
	localparam raddr_t O_DP3  = 6'd7;
	localparam raddr_t O_HDP  = 6'd8;
	localparam raddr_t O_CDP2 = 6'd9;
	localparam raddr_t O_TDP2 = 6'd10;
	localparam raddr_t O_TDP3 = 6'd11;
	localparam raddr_t O_VDP  = 6'd12;
	localparam raddr_t O_DH   = 6'd13;
	localparam raddr_t O_DO   = 6'd14;

	// scratch registers
	localparam raddr_t R_Z      = 6'd16;
	localparam raddr_t R_ONE    = 6'd17;
	localparam raddr_t R_V      = 6'd18;
	localparam raddr_t R_T      = 6'd19;
	localparam raddr_t R_T2     = 6'd20;
	localparam raddr_t R_OMK    = 6'd21;
	localparam raddr_t R_DP     = 6'd22;
	localparam raddr_t R_DPH    = 6'd23;
	localparam raddr_t R_DPP    = 6'd24;
	localparam raddr_t R_DPPDT  = 6'd25;
	localparam raddr_t R_DPPK   = 6'd26;
	localparam raddr_t R_DPPPDT = 6'd27;
	localparam raddr_t R_DPPP   = 6'd28;
	localparam raddr_t R_V2     = 6'd29;
	localparam raddr_t R_V3     = 6'd30;
	localparam raddr_t R_A3V    = 6'd31;
	localparam raddr_t R_R1     = 6'd32;
	localparam raddr_t R_R2     = 6'd33;
	localparam raddr_t R_R3     = 6'd34;
	localparam raddr_t R_R4     = 6'd35;
	localparam raddr_t R_R5     = 6'd36;
	localparam raddr_t R_R6     = 6'd37;
	localparam raddr_t R_R7     = 6'd38;
	localparam raddr_t R_R8     = 6'd39;
	localparam raddr_t R_S      = 6'd40;
	localparam raddr_t R_C      = 6'd41;
	localparam raddr_t R_KK     = 6'd42;
	localparam raddr_t R_TAN    = 6'd43;
	localparam raddr_t R_KT     = 6'd44;
	localparam raddr_t R_C3     = 6'd45;
	localparam raddr_t R_OM2    = 6'd46;
	localparam raddr_t R_CK     = 6'd47;
	localparam raddr_t R_CG     = 6'd48;
	localparam raddr_t R_OM3    = 6'd49;
	localparam raddr_t R_GA     = 6'd50;
	localparam raddr_t R_GC     = 6'd51;
	localparam raddr_t R_GB     = 6'd52;
	localparam raddr_t R_DTH    = 6'd53;
	localparam raddr_t R_SD     = 6'd54;
	localparam raddr_t R_COM    = 6'd55;
	localparam raddr_t R_X      = 6'd56;
	localparam raddr_t R_Y      = 6'd57;
	localparam raddr_t R_BP     = 6'd58;
	localparam raddr_t R_CP     = 6'd59;
	localparam raddr_t R_BA     = 6'd60;
	localparam raddr_t R_CPK    = 6'd61;
	localparam raddr_t R_KC     = 6'd62;

	localparam pc_t PC_ARC  = 8'd32;
	localparam pc_t PC_MAIN = 8'd40;
	localparam pc_t PC_DIS  = 8'd124;

	function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] v);
		return v[QW-1] ? QW'(-v) : QW'(v);
	endfunction

	function automatic logic signed [QW-1:0] with_sign(input logic [QW-1:0] m, input logic neg);
		logic [QW-1:0] c;
		c = (m > Q_MAX) ? Q_MAX : m;
		return neg ? -$signed(c) : $signed(c);
	endfunction

	function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [QW:0] s;
		s = (QW+1)'(a) + (QW+1)'(b);
		if (s > (QW+1)'(Q_MAX))
			return Q_MAX;
		if (s < -(QW+1)'(Q_MAX))
			return -Q_MAX;
		return QW'(s);
	endfunction

	function automatic logic signed [QW-1:0] guard(input logic signed [QW-1:0] v);
		if (v > -Q_EPS && v < Q_EPS)
			return v[QW-1] ? -Q_EPS : Q_EPS;
		return v;
	endfunction

	// atan(2^-i) in q.32
	function automatic logic signed [QW-1:0] cordic_angle(input logic [4:0] i);
		logic signed [QW-1:0] t;
		case (i)
			5'd0:  t = 64'sh C90F_DAA2;
			5'd1:  t = 64'sh 76B1_9C16;
			5'd2:  t = 64'sh 3EB6_EBF2;
			5'd3:  t = 64'sh 1FD5_BA9B;
			5'd4:  t = 64'sh 0FFA_ADDC;
			5'd5:  t = 64'sh 07FF_556F;
			5'd6:  t = 64'sh 03FF_EAAB;
			5'd7:  t = 64'sh 01FF_FD55;
			5'd8:  t = 64'sh 00FF_FFAB;
			5'd9:  t = 64'sh 007F_FFF5;
			5'd10: t = 64'sh 003F_FFFF;
			default: t = $signed(64'd1 << (6'd32 - {1'b0, i}));
		endcase
		return t;
	endfunction

	function automatic uinstr_t mk(input uop_t op, input raddr_t dst, input raddr_t a,
			input raddr_t b, input pc_t imm);
		uinstr_t u;
		u.op  = op;
		u.dst = dst;
		u.a   = a;
		u.b   = b;
		u.imm = imm;
		return u;
	endfunction

	function automatic uinstr_t ucode(input pc_t pc);
		uinstr_t u;
		case (pc)
			// prologue
			8'd0:   u = mk(OP_LDC,  R_Z,      R_Z,      R_Z,      C_ZERO);
			8'd1:   u = mk(OP_LDC,  R_ONE,    R_Z,      R_Z,      C_ONE);
			8'd2:   u = mk(OP_JDIS, R_Z,      R_Z,      R_Z,      PC_DIS);
			8'd3:   u = mk(OP_GRD,  R_V,      O_V,      O_V,      C_ZERO);
			8'd4:   u = mk(OP_MUL,  R_T,      O_KR,     O_D,      C_ZERO);
			8'd5:   u = mk(OP_SUB,  R_T,      R_ONE,    R_T,      C_ZERO);
			8'd6:   u = mk(OP_GRD,  R_OMK,    R_T,      R_T,      C_ZERO);
			8'd7:   u = mk(OP_JARC, R_Z,      R_Z,      R_Z,      PC_ARC);
			// time to arc-length derivatives
			8'd8:   u = mk(OP_DIV,  R_DP,     O_DP1,    R_V,      C_ZERO);
			8'd9:   u = mk(OP_DIV,  R_DPH,    O_HDP,    R_V,      C_ZERO);
			8'd10:  u = mk(OP_MUL,  R_V2,     R_V,      R_V,      C_ZERO);
			8'd11:  u = mk(OP_MUL,  R_V3,     R_V2,     R_V,      C_ZERO);
			8'd12:  u = mk(OP_MUL,  R_T,      O_A,      R_DP,     C_ZERO);
			8'd13:  u = mk(OP_SUB,  R_T2,     O_DP2,    R_T,      C_ZERO);
			8'd14:  u = mk(OP_DIV,  R_DPP,    R_T2,     R_V2,     C_ZERO);
			8'd15:  u = mk(OP_SUB,  R_T2,     O_TDP2,   R_T,      C_ZERO);
			8'd16:  u = mk(OP_DIV,  R_DPPDT,  R_T2,     R_V2,     C_ZERO);
			8'd17:  u = mk(OP_SUB,  R_T2,     O_CDP2,   R_T,      C_ZERO);
			8'd18:  u = mk(OP_DIV,  R_DPPK,   R_T2,     R_V2,     C_ZERO);
			8'd19:  u = mk(OP_ADD,  R_T2,     O_A,      O_A,      C_ZERO);
			8'd20:  u = mk(OP_ADD,  R_T2,     O_A,      R_T2,     C_ZERO);
			8'd21:  u = mk(OP_MUL,  R_A3V,    R_T2,     R_V,      C_ZERO);
			8'd22:  u = mk(OP_MUL,  R_T,      R_A3V,    R_DPPDT,  C_ZERO);
			8'd23:  u = mk(OP_SUB,  R_T,      O_TDP3,   R_T,      C_ZERO);
			8'd24:  u = mk(OP_DIV,  R_DPPPDT, R_T,      R_V3,     C_ZERO);
			8'd25:  u = mk(OP_MUL,  R_T,      R_A3V,    R_DPP,    C_ZERO);
			8'd26:  u = mk(OP_SUB,  R_T,      O_DP3,    R_T,      C_ZERO);
			8'd27:  u = mk(OP_DIV,  R_DPPP,   R_T,      R_V3,     C_ZERO);
			8'd28:  u = mk(OP_DIV,  R_T,      O_VDP,    R_V,      C_ZERO);
			8'd29:  u = mk(OP_DIV,  R_T,      R_T,      R_OMK,    C_ZERO);
			8'd30:  u = mk(OP_ATAN, R_R8,     R_T,      R_T,      C_ZERO);
			8'd31:  u = mk(OP_JMP,  R_Z,      R_Z,      R_Z,      PC_MAIN);
			// arc-length mode copies
			8'd32:  u = mk(OP_ADD,  R_DP,     O_DP1,    R_Z,      C_ZERO);
			8'd33:  u = mk(OP_ADD,  R_DPH,    O_HDP,    R_Z,      C_ZERO);
			8'd34:  u = mk(OP_ADD,  R_DPP,    O_DP2,    R_Z,      C_ZERO);
			8'd35:  u = mk(OP_ADD,  R_DPPDT,  O_TDP2,   R_Z,      C_ZERO);
			8'd36:  u = mk(OP_ADD,  R_DPPK,   O_CDP2,   R_Z,      C_ZERO);
			8'd37:  u = mk(OP_ADD,  R_DPPPDT, O_TDP3,   R_Z,      C_ZERO);
			8'd38:  u = mk(OP_ADD,  R_DPPP,   O_DP3,    R_Z,      C_ZERO);
			8'd39:  u = mk(OP_ADD,  R_R8,     O_DH,     R_Z,      C_ZERO);
			// headings and curvatures
			8'd40:  u = mk(OP_DIV,  R_T,      R_DP,     R_OMK,    C_ZERO);
			8'd41:  u = mk(OP_ATAN, R_R1,     R_T,      R_T,      C_ZERO);
			8'd42:  u = mk(OP_DIV,  R_T,      R_DPH,    R_OMK,    C_ZERO);
			8'd43:  u = mk(OP_ATAN, R_R2,     R_T,      R_T,      C_ZERO);
			8'd44:  u = mk(OP_SC,   R_S,      R_R1,     R_R1,     C_ZERO);
			8'd45:  u = mk(OP_MUL,  R_T,      O_KR,     R_DP,     C_ZERO);
			8'd46:  u = mk(OP_MUL,  R_T2,     O_KRP,    O_D,      C_ZERO);
			8'd47:  u = mk(OP_ADD,  R_KK,     R_T,      R_T2,     C_ZERO);
			8'd48:  u = mk(OP_GRD,  R_CG,     R_C,      R_C,      C_ZERO);
			8'd49:  u = mk(OP_DIV,  R_TAN,    R_S,      R_CG,     C_ZERO);
			8'd50:  u = mk(OP_MUL,  R_KT,     R_KK,     R_TAN,    C_ZERO);
			8'd51:  u = mk(OP_MUL,  R_T,      R_C,      R_C,      C_ZERO);
			8'd52:  u = mk(OP_MUL,  R_C3,     R_T,      R_C,      C_ZERO);
			8'd53:  u = mk(OP_MUL,  R_OM2,    R_OMK,    R_OMK,    C_ZERO);
			8'd54:  u = mk(OP_DIV,  R_T,      R_C,      R_OMK,    C_ZERO);
			8'd55:  u = mk(OP_MUL,  R_CK,     R_T,      O_KR,     C_ZERO);
			8'd56:  u = mk(OP_ADD,  R_T,      R_DPP,    R_KT,     C_ZERO);
			8'd57:  u = mk(OP_MUL,  R_T,      R_T,      R_C3,     C_ZERO);
			8'd58:  u = mk(OP_DIV,  R_T,      R_T,      R_OM2,    C_ZERO);
			8'd59:  u = mk(OP_ADD,  R_R3,     R_T,      R_CK,     C_ZERO);
			8'd60:  u = mk(OP_ADD,  R_T,      R_DPPDT,  R_KT,     C_ZERO);
			8'd61:  u = mk(OP_MUL,  R_T,      R_T,      R_C3,     C_ZERO);
			8'd62:  u = mk(OP_DIV,  R_T,      R_T,      R_OM2,    C_ZERO);
			8'd63:  u = mk(OP_ADD,  R_R4,     R_T,      R_CK,     C_ZERO);
			8'd64:  u = mk(OP_ADD,  R_T,      R_DPPK,   R_KT,     C_ZERO);
			8'd65:  u = mk(OP_MUL,  R_T,      R_T,      R_C3,     C_ZERO);
			8'd66:  u = mk(OP_DIV,  R_T,      R_T,      R_OM2,    C_ZERO);
			8'd67:  u = mk(OP_ADD,  R_R5,     R_T,      R_CK,     C_ZERO);
			// curvature gradient terms
			8'd68:  u = mk(OP_MUL,  R_OM3,    R_OM2,    R_OMK,    C_ZERO);
			8'd69:  u = mk(OP_ADD,  R_GA,     R_DPP,    R_KT,     C_ZERO);
			8'd70:  u = mk(OP_DIV,  R_GC,     R_CG,     R_OMK,    C_ZERO);
			8'd71:  u = mk(OP_MUL,  R_T,      R_GC,     R_GC,     C_ZERO);
			8'd72:  u = mk(OP_MUL,  R_GB,     R_T,      R_CG,     C_ZERO);
			8'd73:  u = mk(OP_GRD,  R_T,      R_GC,     R_GC,     C_ZERO);
			8'd74:  u = mk(OP_DIV,  R_T,      R_R3,     R_T,      C_ZERO);
			8'd75:  u = mk(OP_SUB,  R_DTH,    R_T,      O_KR,     C_ZERO);
			8'd76:  u = mk(OP_MUL,  R_SD,     R_S,      R_DTH,    C_ZERO);
			8'd77:  u = mk(OP_MUL,  R_T,      R_CG,     R_KK,     C_ZERO);
			8'd78:  u = mk(OP_MUL,  R_T2,     R_SD,     R_OMK,    C_ZERO);
			8'd79:  u = mk(OP_SUB,  R_COM,    R_T,      R_T2,     C_ZERO);
			8'd80:  u = mk(OP_ADD,  R_T,      R_DP,     R_DP,     C_ZERO);
			8'd81:  u = mk(OP_MUL,  R_T,      R_T,      O_KRP,    C_ZERO);
			8'd82:  u = mk(OP_MUL,  R_T2,     R_DPP,    O_KR,     C_ZERO);
			8'd83:  u = mk(OP_ADD,  R_T,      R_T,      R_T2,     C_ZERO);
			8'd84:  u = mk(OP_MUL,  R_X,      R_T,      R_TAN,    C_ZERO);
			8'd85:  u = mk(OP_DIV,  R_T,      R_ONE,    R_CG,     C_ZERO);
			8'd86:  u = mk(OP_DIV,  R_T,      R_T,      R_CG,     C_ZERO);
			8'd87:  u = mk(OP_MUL,  R_T,      R_KK,     R_T,      C_ZERO);
			8'd88:  u = mk(OP_MUL,  R_Y,      R_T,      R_DTH,    C_ZERO);
			8'd89:  u = mk(OP_ADD,  R_T,      R_CG,     R_CG,     C_ZERO);
			8'd90:  u = mk(OP_MUL,  R_T,      R_T,      R_CG,     C_ZERO);
			8'd91:  u = mk(OP_MUL,  R_T,      R_T,      R_COM,    C_ZERO);
			8'd92:  u = mk(OP_DIV,  R_T,      R_T,      R_OM3,    C_ZERO);
			8'd93:  u = mk(OP_MUL,  R_T2,     R_SD,     R_GC,     C_ZERO);
			8'd94:  u = mk(OP_MUL,  R_T2,     R_T2,     R_GC,     C_ZERO);
			8'd95:  u = mk(OP_SUB,  R_BP,     R_T,      R_T2,     C_ZERO);
			8'd96:  u = mk(OP_DIV,  R_CP,     R_COM,    R_OM2,    C_ZERO);
			8'd97:  u = mk(OP_MUL,  R_BA,     R_BP,     R_GA,     C_ZERO);
			8'd98:  u = mk(OP_MUL,  R_CPK,    R_CP,     O_KR,     C_ZERO);
			8'd99:  u = mk(OP_MUL,  R_KC,     O_KRP,    R_GC,     C_ZERO);
			8'd100: u = mk(OP_ADD,  R_T,      R_DPPPDT, R_X,      C_ZERO);
			8'd101: u = mk(OP_ADD,  R_T,      R_T,      R_Y,      C_ZERO);
			8'd102: u = mk(OP_MUL,  R_T,      R_T,      R_GB,     C_ZERO);
			8'd103: u = mk(OP_ADD,  R_T,      R_T,      R_BA,     C_ZERO);
			8'd104: u = mk(OP_ADD,  R_T,      R_T,      R_CPK,    C_ZERO);
			8'd105: u = mk(OP_ADD,  R_T,      R_T,      R_KC,     C_ZERO);
			8'd106: u = mk(OP_MUL,  R_R6,     R_V,      R_T,      C_ZERO);
			8'd107: u = mk(OP_ADD,  R_T,      R_DPPP,   R_X,      C_ZERO);
			8'd108: u = mk(OP_ADD,  R_T,      R_T,      R_Y,      C_ZERO);
			8'd109: u = mk(OP_MUL,  R_T,      R_T,      R_GB,     C_ZERO);
			8'd110: u = mk(OP_ADD,  R_T,      R_T,      R_BA,     C_ZERO);
			8'd111: u = mk(OP_ADD,  R_T,      R_T,      R_CPK,    C_ZERO);
			8'd112: u = mk(OP_ADD,  R_T,      R_T,      R_KC,     C_ZERO);
			8'd113: u = mk(OP_MUL,  R_R7,     R_V,      R_T,      C_ZERO);
			// result words
			8'd114: u = mk(OP_EMIT, R_Z,      O_D,      O_D,      8'd0);
			8'd115: u = mk(OP_EMIT, R_Z,      R_R1,     R_R1,     8'd1);
			8'd116: u = mk(OP_EMIT, R_Z,      R_R2,     R_R2,     8'd2);
			8'd117: u = mk(OP_EMIT, R_Z,      R_R3,     R_R3,     8'd3);
			8'd118: u = mk(OP_EMIT, R_Z,      R_R4,     R_R4,     8'd4);
			8'd119: u = mk(OP_EMIT, R_Z,      R_R5,     R_R5,     8'd5);
			8'd120: u = mk(OP_EMIT, R_Z,      R_R6,     R_R6,     8'd6);
			8'd121: u = mk(OP_EMIT, R_Z,      R_R7,     R_R7,     8'd7);
			8'd122: u = mk(OP_EMIT, R_Z,      R_R8,     R_R8,     8'd8);
			8'd123: u = mk(OP_EMIT, R_Z,      O_DO,     O_DO,     RESULT_LAST);
			// disabled answer
			8'd124: u = mk(OP_EMIT, R_Z,      R_Z,      R_Z,      8'd0);
			8'd125: u = mk(OP_EMIT, R_Z,      R_Z,      R_Z,      8'd1);
			8'd126: u = mk(OP_EMIT, R_Z,      R_Z,      R_Z,      8'd2);
			8'd127: u = mk(OP_EMIT, R_Z,      R_Z,      R_Z,      8'd3);
			8'd128: u = mk(OP_EMIT, R_Z,      R_Z,      R_Z,      8'd4);
			8'd129: u = mk(OP_EMIT, R_Z,      R_Z,      R_Z,      8'd5);
			8'd130: u = mk(OP_EMIT, R_Z,      R_Z,      R_Z,      8'd6);
			8'd131: u = mk(OP_EMIT, R_Z,      R_Z,      R_Z,      8'd7);
			8'd132: u = mk(OP_EMIT, R_Z,      O_DH,     O_DH,     8'd8);
			8'd133: u = mk(OP_EMIT, R_Z,      O_DO,     O_DO,     RESULT_LAST);
			default: u = mk(OP_EMIT, R_Z,     R_Z,      R_Z,      RESULT_LAST);
		endcase
		return u;
	endfunction

endpackage

// ===== design/frenet_back_transform_curvature_unit.sv =====
// frenet_back_transform_curvature_unit: top level, microcoded sequencer over one
// shared multiply / divide / cordic unit and a scratch register memory
// depends on fbt_pkg
//
// A load word (mode 0) is accepted whenever busy is low; it gives no result. A
// compute word (mode 1) copies the fifteen operands into the scratch memory,
// then runs a microprogram through one shared arithmetic unit: a multiply sums
// four 32x32 partial products, a divide runs a 96-step restoring divider, and a
// cordic pass gives an arctangent or a sine and cosine, with a reciprocal through
// the divider first for an arctangent of a ratio whose magnitude is above one.
// In arc-length mode the divides for the time to arc-length derivatives are
// skipped, and when guidance is disabled or there is no trajectory the unit goes
// straight to the disabled answer words. The ten result words each show for one
// cycle under result_strobe; the receiver must take them as they come.
module frenet_back_transform_curvature_unit #(
	parameter int VALUE_WIDTH = fbt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [3:0]                    slot,
	input  logic signed [VALUE_WIDTH-1:0] operand_value,
	input  logic                          guidance_enable,
	input  logic                          no_trajectory,
	input  logic                          arc_length_mode,
	output logic                          result_strobe,
	output logic [3:0]                    result_slot,
	output logic signed [VALUE_WIDTH-1:0] result_value,
	output logic                          last
);
	import fbt_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_COPY  = 4'd1;
	localparam logic [3:0] S_FETCH = 4'd2;
	localparam logic [3:0] S_EXEC  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_MULF  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_DIVF  = 4'd7;
	localparam logic [3:0] S_COR   = 4'd8;
	localparam logic [3:0] S_CORF  = 4'd9;
	localparam logic [3:0] S_WB    = 4'd10;
	localparam logic [3:0] S_WB2   = 4'd11;

	localparam logic signed [QW-1:0] FMAX = $signed((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
	localparam logic signed [QW-1:0] FMIN = -FMAX - 64'sd1;
	localparam logic signed [QW-1:0] QMIN = -Q_MAX - 64'sd1;

	logic [3:0]  state_q;
	pc_t         pc_q;
	logic [6:0]  cnt_q;
	logic        dis_q;
	logic        arc_q;
	uinstr_t     ui;

	logic signed [VALUE_WIDTH-1:0] store_q [NUM_OPS];
	logic signed [QW-1:0]          mem [MEM_DEPTH];
	logic signed [QW-1:0]          rda_q;
	logic signed [QW-1:0]          rdb_q;
	logic                          we;
	raddr_t                        waddr;
	logic signed [QW-1:0]          wdata;
	logic signed [QW-1:0]          cpy_ext;
	logic signed [QW-1:0]          res_q;

	// multiplier
	logic [QW-1:0]   ma_q, mb_q;
	logic [127:0]    acc_q;
	logic            neg_q;
	logic [31:0]     pa, pb;
	logic [63:0]     prod;
	logic [127:0]    acc_n;
	logic [127:0]    rnd;
	logic signed [QW-1:0] mul_val;

	// divider
	logic [95:0]     dq_q;
	logic [QW-1:0]   rem_q;
	logic [QW-1:0]   den_q;
	logic            nz_q, dz_q;
	logic [QW:0]     rem2;
	logic            ge;
	logic signed [QW-1:0] div_num, div_den, div_val;

	// cordic
	logic signed [QW-1:0] x_q, y_q, z_q;
	logic            vec_q, inv_q, qpos_q;
	logic signed [QW-1:0] dx, dy, ang;
	logic            pos;

	logic signed [QW-1:0] emit_val;

	assign ui   = ucode(pc_q);
	assign busy = (state_q != S_IDLE);

	// operand widening on copy
	always_comb begin
		cpy_ext = QW'(store_q[cnt_q[3:0]]);
		if (cpy_ext == QMIN)
			cpy_ext = -Q_MAX;
	end

	always_comb begin
		we    = 1'b0;
		waddr = ui.dst;
		wdata = res_q;
		case (state_q)
			S_COPY: begin
				we    = 1'b1;
				waddr = raddr_t'(cnt_q);
				wdata = cpy_ext;
			end
			S_WB: begin
				we = 1'b1;
			end
			S_WB2: begin
				we    = 1'b1;
				waddr = ui.dst + 6'd1;
				wdata = x_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rda_q <= mem[ui.a];
		rdb_q <= mem[ui.b];
	end

	// multiplier step and rounding
	always_comb begin
		pa      = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		pb      = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		prod    = 64'(pa) * 64'(pb);
		acc_n   = acc_q + ({64'd0, prod} << (7'd32 * (7'(cnt_q[1]) + 7'(cnt_q[0]))));
		rnd     = acc_q + 128'h8000_0000;
		mul_val = with_sign((rnd[127:95] != '0) ? Q_MAX : {1'b0, rnd[94:32]}, neg_q);
	end

	// divider step and result
	always_comb begin
		div_num = (ui.op == OP_ATAN) ? Q_ONE : rda_q;
		div_den = (ui.op == OP_ATAN) ? rda_q : rdb_q;
		rem2    = {rem_q, dq_q[95]};
		ge      = (rem2 >= {1'b0, den_q});
		if (nz_q)
			div_val = '0;
		else if (dz_q || dq_q[95:63] != '0)
			div_val = with_sign(Q_MAX, neg_q);
		else
			div_val = with_sign({1'b0, dq_q[62:0]}, neg_q);
	end

	// cordic step
	always_comb begin
		dx  = y_q >>> cnt_q[4:0];
		dy  = x_q >>> cnt_q[4:0];
		ang = cordic_angle(cnt_q[4:0]);
		pos = vec_q ? y_q[QW-1] : !z_q[QW-1];
	end

	// result saturation to the word range
	always_comb begin
		emit_val = rda_q;
		if (rda_q > FMAX)
			emit_val = FMAX;
		else if (rda_q < FMIN)
			emit_val = FMIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pc_q          <= '0;
			cnt_q         <= '0;
			dis_q         <= 1'b0;
			arc_q         <= 1'b0;
			result_strobe <= 1'b0;
			last          <= 1'b0;
			for (int i = 0; i < NUM_OPS; i++)
				store_q[i] <= '0;
		end else begin
			result_strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (!mode) begin
							if (slot < 4'(NUM_OPS))
								store_q[slot] <= operand_value;
						end else begin
							dis_q   <= !guidance_enable || no_trajectory;
							arc_q   <= arc_length_mode;
							cnt_q   <= '0;
							state_q <= S_COPY;
						end
					end
				end
				S_COPY: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(NUM_OPS - 1)) begin
						pc_q    <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					cnt_q <= '0;
					case (ui.op)
						OP_ADD: begin
							res_q   <= sat_add(rda_q, rdb_q);
							state_q <= S_WB;
						end
						OP_SUB: begin
							res_q   <= sat_add(rda_q, -rdb_q);
							state_q <= S_WB;
						end
						OP_GRD: begin
							res_q   <= guard(rda_q);
							state_q <= S_WB;
						end
						OP_LDC: begin
							res_q   <= (ui.imm == C_ONE) ? Q_ONE : '0;
							state_q <= S_WB;
						end
						OP_MUL: begin
							ma_q    <= mag(rda_q);
							mb_q    <= mag(rdb_q);
							neg_q   <= rda_q[QW-1] ^ rdb_q[QW-1];
							acc_q   <= '0;
							state_q <= S_MUL;
						end
						OP_DIV: begin
							dq_q    <= {mag(div_num), 32'd0};
							rem_q   <= '0;
							den_q   <= mag(div_den);
							nz_q    <= (div_num == '0);
							dz_q    <= (div_den == '0);
							neg_q   <= div_num[QW-1] ^ div_den[QW-1];
							state_q <= S_DIV;
						end
						OP_ATAN: begin
							qpos_q <= !rda_q[QW-1];
							vec_q  <= 1'b1;
							x_q    <= Q_ONE;
							z_q    <= '0;
							y_q    <= rda_q;
							if (rda_q > Q_ONE || rda_q < -Q_ONE) begin
								inv_q   <= 1'b1;
								dq_q    <= {mag(div_num), 32'd0};
								rem_q   <= '0;
								den_q   <= mag(div_den);
								nz_q    <= 1'b0;
								dz_q    <= 1'b0;
								neg_q   <= div_den[QW-1];
								state_q <= S_DIV;
							end else begin
								inv_q   <= 1'b0;
								state_q <= S_COR;
							end
						end
						OP_SC: begin
							vec_q   <= 1'b0;
							inv_q   <= 1'b0;
							x_q     <= Q_GAIN;
							y_q     <= '0;
							z_q     <= rda_q;
							state_q <= S_COR;
						end
						OP_EMIT: begin
							result_strobe <= 1'b1;
							result_slot   <= ui.imm[3:0];
							result_value  <= VALUE_WIDTH'(emit_val);
							last          <= (ui.imm == RESULT_LAST);
							if (ui.imm == RESULT_LAST) begin
								state_q <= S_IDLE;
							end else begin
								pc_q    <= pc_q + 8'd1;
								state_q <= S_FETCH;
							end
						end
						OP_JDIS: begin
							pc_q    <= dis_q ? ui.imm : pc_q + 8'd1;
							state_q <= S_FETCH;
						end
						OP_JARC: begin
							pc_q    <= arc_q ? ui.imm : pc_q + 8'd1;
							state_q <= S_FETCH;
						end
						OP_JMP: begin
							pc_q    <= ui.imm;
							state_q <= S_FETCH;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_MUL: begin
					acc_q <= acc_n;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[1:0] == 2'd3)
						state_q <= S_MULF;
				end
				S_MULF: begin
					res_q   <= mul_val;
					state_q <= S_WB;
				end
				S_DIV: begin
					rem_q <= ge ? QW'(rem2 - {1'b0, den_q}) : QW'(rem2);
					dq_q  <= {dq_q[94:0], ge};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd95)
						state_q <= S_DIVF;
				end
				S_DIVF: begin
					cnt_q <= '0;
					if (ui.op == OP_ATAN) begin
						y_q     <= div_val;
						state_q <= S_COR;
					end else begin
						res_q   <= div_val;
						state_q <= S_WB;
					end
				end
				S_COR: begin
					if (pos) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - ang;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + ang;
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[4:0] == 5'd31)
						state_q <= S_CORF;
				end
				S_CORF: begin
					if (ui.op == OP_SC)
						res_q <= y_q;
					else if (!inv_q)
						res_q <= z_q;
					else if (qpos_q)
						res_q <= Q_HPI - z_q;
					else
						res_q <= -Q_HPI - z_q;
					state_q <= S_WB;
				end
				S_WB: begin
					if (ui.op == OP_SC) begin
						state_q <= S_WB2;
					end else begin
						pc_q    <= pc_q + 8'd1;
						state_q <= S_FETCH;
					end
				end
				S_WB2: begin
					pc_q    <= pc_q + 8'd1;
					state_q <= S_FETCH;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
